// ===== rtl/touch_cell_occupancy_map_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Touch cell occupancy map assertion macros
// Shared property forms for the checker of the occupancy map unit.
// ----------------------------------------------------------------------------
`ifndef TOUCH_CELL_OCCUPANCY_MAP_UNIT_ASSERT_SVH
`define TOUCH_CELL_OCCUPANCY_MAP_UNIT_ASSERT_SVH

// Overlapping implication, sampled on the rising clock edge outside reset.
`define TCOM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TCOM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tcom_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch cell occupancy map package
// Map dimensions, field widths, request codes and controller types.
// ----------------------------------------------------------------------------
package tcom_pkg;

	localparam int NUM_ROWS    = 7;
	localparam int NUM_COLUMNS = 10;
	localparam int ROW_IW      = $clog2(NUM_ROWS);
	localparam int COL_IW      = $clog2(NUM_COLUMNS);

	localparam int REQ_W = 3;
	localparam int COL_W = 4;
	localparam int ROW_W = 3;
	localparam int GAP_W = 3;

	localparam logic [GAP_W-1:0] GAP_RESET = 3'd3;

	localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SET_CELL   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR_CELL = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SET_AREA   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR_AREA = 3'd4;
	localparam logic [REQ_W-1:0] REQ_CLEAR_ALL  = 3'd5;

	typedef logic [NUM_COLUMNS-1:0] row_bits_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic cfg_wr;
	} dp_cmd_t;

endpackage

// ===== rtl/tcom_ctrl.sv =====
// ----------------------------------------------------------------------------
// Touch cell occupancy map controller
// Sequences request capture, execution and the result strobe.
// ----------------------------------------------------------------------------
module tcom_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             cfg_valid,
	output logic             busy,
	output logic             cfg_ready,
	output logic             done,
	output tcom_pkg::dp_cmd_t cmd
);
	import tcom_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_next;
	logic        done_q;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			done_q  <= (state_q == ST_EXEC);
		end
	end

	assign busy        = (state_q == ST_EXEC);
	assign cfg_ready   = (state_q == ST_IDLE);
	assign done        = done_q;
	assign cmd.capture = start && (state_q == ST_IDLE);
	assign cmd.exec    = (state_q == ST_EXEC);
	assign cmd.cfg_wr  = cfg_valid && (state_q == ST_IDLE);

endmodule

// ===== rtl/tcom_dp.sv =====
// ----------------------------------------------------------------------------
// Touch cell occupancy map datapath
// Holds the cell map and gap register, evaluates and applies one request.
// ----------------------------------------------------------------------------
module tcom_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcom_pkg::dp_cmd_t            cmd,
	input  logic [tcom_pkg::GAP_W-1:0]   cfg_data,
	input  logic [tcom_pkg::REQ_W-1:0]   req_type,
	input  logic [tcom_pkg::COL_W-1:0]   column,
	input  logic [tcom_pkg::ROW_W-1:0]   row,
	output logic                         coord_valid,
	output logic                         cell_was_set,
	output logic                         any_cell_set,
	output logic                         pen_possible
);
	import tcom_pkg::*;

	row_bits_t          map_q [NUM_ROWS];
	row_bits_t          map_next [NUM_ROWS];
	logic [GAP_W-1:0]   gap_q;
	logic [REQ_W-1:0]   op_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic               valid_q;
	logic               was_q;
	logic               any_q;
	logic               pen_q;

	logic               coord_ok;
	logic               was;
	logic               any;
	logic               tail_busy;
	logic [ROW_W:0]     gap_lim;
	logic [ROW_W:0]     row_ext;
	logic [ROW_W:0]     row_i;
	logic               in_row;
	logic               in_area;
	row_bits_t          rows_or;
	row_bits_t          bit_mask;
	row_bits_t          span;
	logic [NUM_COLUMNS+1:0] span_wide;

	always_comb begin
		row_ext  = {1'b0, row_q};
		coord_ok = ({1'b0, col_q} < (COL_W+1)'(NUM_COLUMNS)) &&
			(row_ext < (ROW_W+1)'(NUM_ROWS));
		was      = coord_ok && map_q[row_q[ROW_IW-1:0]][col_q[COL_IW-1:0]];
		gap_lim  = row_ext + {1'b0, gap_q};
		tail_busy = 1'b0;
		rows_or  = '0;
		for (int i = 0; i < NUM_ROWS; i++) begin
			rows_or = rows_or | map_q[i];
			if (((ROW_W+1)'(i) >= gap_lim) && (|map_q[i])) begin
				tail_busy = 1'b1;
			end
		end
		any       = |rows_or;
		bit_mask  = row_bits_t'(1) << col_q;
		span_wide = (NUM_COLUMNS+2)'(3'b111) << col_q;
		span      = span_wide[NUM_COLUMNS:1];
		in_row    = 1'b0;
		in_area   = 1'b0;
		row_i     = '0;
		for (int i = 0; i < NUM_ROWS; i++) begin
			row_i       = (ROW_W+1)'(i);
			in_row      = (row_i == row_ext);
			in_area     = in_row || ((row_i + 1'b1) == row_ext) || (row_i == (row_ext + 1'b1));
			map_next[i] = map_q[i];
			if (op_q == REQ_CLEAR_ALL) begin
				map_next[i] = '0;
			end else if (coord_ok) begin
				priority if (op_q == REQ_SET_CELL && in_row) begin
					map_next[i] = map_q[i] | bit_mask;
				end else if (op_q == REQ_CLEAR_CELL && in_row) begin
					map_next[i] = map_q[i] & ~bit_mask;
				end else if (op_q == REQ_SET_AREA && in_area) begin
					map_next[i] = map_q[i] | span;
				end else if (op_q == REQ_CLEAR_AREA && in_area) begin
					map_next[i] = map_q[i] & ~span;
				end else begin
					map_next[i] = map_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ROWS; i++) begin
				map_q[i] <= '0;
			end
			gap_q <= GAP_RESET;
		end else begin
			if (cmd.exec) begin
				for (int i = 0; i < NUM_ROWS; i++) begin
					map_q[i] <= map_next[i];
				end
			end
			if (cmd.cfg_wr) begin
				gap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= req_type;
			col_q <= column;
			row_q <= row;
		end
		if (cmd.exec) begin
			valid_q <= coord_ok;
			was_q   <= was;
			any_q   <= any;
			pen_q   <= coord_ok && !was && !tail_busy;
		end
	end

	assign coord_valid  = valid_q;
	assign cell_was_set = was_q;
	assign any_cell_set = any_q;
	assign pen_possible = pen_q;

endmodule

// ===== rtl/touch_cell_occupancy_map_unit.sv =====
// A result beat is strobed on done once the request has passed the execute state and the done register.
// A new request is taken only while idle; busy marks the single execute state of the controller.
// The receiver cannot stall: each result beat is strobed on done for exactly one cycle.
// Reset clears the whole cell map and returns the pen row gap to three.
// ----------------------------------------------------------------------------
// Touch cell occupancy map unit
// Cell map for palm rejection with set, clear, area and query requests.
// ----------------------------------------------------------------------------
module touch_cell_occupancy_map_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [tcom_pkg::REQ_W-1:0]   req_type,
	input  logic [tcom_pkg::COL_W-1:0]   column,
	input  logic [tcom_pkg::ROW_W-1:0]   row,
	output logic                         done,
	output logic                         coord_valid,
	output logic                         cell_was_set,
	output logic                         any_cell_set,
	output logic                         pen_possible,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tcom_pkg::GAP_W-1:0]   cfg_data
);
	import tcom_pkg::*;

	dp_cmd_t cmd;

	tcom_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.busy      (busy),
		.cfg_ready (cfg_ready),
		.done      (done),
		.cmd       (cmd)
	);

	tcom_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_data     (cfg_data),
		.req_type     (req_type),
		.column       (column),
		.row          (row),
		.coord_valid  (coord_valid),
		.cell_was_set (cell_was_set),
		.any_cell_set (any_cell_set),
		.pen_possible (pen_possible)
	);

endmodule

// ===== rtl/tcom_checker.sv =====
// ----------------------------------------------------------------------------
// Touch cell occupancy map checker
// Port-level properties of the occupancy map unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "touch_cell_occupancy_map_unit_assert.svh"

module tcom_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic                       coord_valid,
	input logic                       cell_was_set,
	input logic                       pen_possible
);

	`TCOM_ASSERT_NXT(a_accept_busy, start && !busy, busy, "Accepted beat did not raise busy.")
	`TCOM_ASSERT_IMP(a_accept_done, start && !busy, ##2 done, "No result beat two cycles after start.")
	`TCOM_ASSERT_IMP(a_done_idle, done, !busy, "Result beat shown while busy.")
	`TCOM_ASSERT_IMP(a_invalid_clean, done && !coord_valid, !cell_was_set && !pen_possible,
		"Invalid coordinate reported a set cell or a pen.")
	`TCOM_ASSERT_IMP(a_pen_clear, done && pen_possible, !cell_was_set && coord_valid,
		"Pen reported on a set or invalid cell.")

endmodule

bind touch_cell_occupancy_map_unit tcom_checker u_tcom_checker (.*);
